// ----- rtl/legendre_series_evaluator_top_macros.svh -----
// Assertion macros for the Legendre series evaluator checker.
// Used by the checker file only; holds no logic of its own.
`ifndef LEGENDRE_SERIES_EVALUATOR_TOP_MACROS_SVH
`define LEGENDRE_SERIES_EVALUATOR_TOP_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define LSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("legendre_series_evaluator_top: port check failed");

// Next-cycle implication, switched off while reset is held.
`define LSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("legendre_series_evaluator_top: port check failed");

// Next-cycle implication that also holds across reset.
`define LSE_ASSERT_NXT_ALL(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("legendre_series_evaluator_top: port check failed");

`endif

// ----- rtl/lse_pkg.sv -----
// Shared types and constants of the Legendre series evaluator.
// Used by every module of the block; depends on nothing.
package lse_pkg;

    localparam int DATA_W    = 32;
    localparam int COEF_W    = 32;
    localparam int CFG_IDX_W = 4;
    localparam int IFRAC     = 30;   // fraction bits of t and P(n)
    localparam int GUARD     = 14;   // extra fraction bits in the accumulator
    localparam int T_W       = 32;
    localparam int P_W       = 34;
    localparam int ACC_W     = 52;
    localparam int NUM_W     = 38;
    localparam int RECIP_W   = 31;
    localparam int SUM_W     = 40;
    localparam int MAX_TERMS = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MID     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_HALF_SPAN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0        = 4'd2;

    localparam logic signed [P_W-1:0] P_ONE = P_W'(64'd1 << IFRAC);

    // 1/k in unsigned Q1.30, rounded to nearest.
    localparam logic [RECIP_W-1:0] RECIP_TAB [MAX_TERMS+1] = '{
        31'd0, 31'd1073741824, 31'd536870912, 31'd357913941,
        31'd268435456, 31'd214748365, 31'd178956971
    };

    // State handed from cell to cell.
    typedef struct packed {
        logic signed [T_W-1:0]   t;
        logic signed [P_W-1:0]   p_prev;
        logic signed [P_W-1:0]   p_cur;
        logic signed [ACC_W-1:0] acc;
        logic                    clamped;
    } lse_bus_t;

endpackage

// ----- rtl/lse_front.sv -----
// Front end: maps a sample onto [-1,1] in Q2.30 and clamps it, in three stages.
// Depends on lse_pkg.
module lse_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [lse_pkg::DATA_W-1:0] sample_x,
    input  logic signed [lse_pkg::DATA_W-1:0] range_mid,
    input  logic        [lse_pkg::DATA_W-1:0] inv_half_span,
    output logic                             out_valid,
    input  logic                             out_ready,
    output lse_pkg::lse_bus_t                out_bus
);
    import lse_pkg::*;

    localparam int SH = 2 * FRAC_BITS - IFRAC;
    localparam logic [63:0] X_ONE = 64'd1 << (2 * FRAC_BITS);

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    logic [DATA_W:0]   diff;
    logic [DATA_W:0]   diff_mag;
    logic              d_neg_reg;
    logic [DATA_W-1:0] d_mag_reg;

    logic [63:0] prod_next;
    logic [63:0] prod_reg;
    logic        p_neg_reg;

    logic        clip;
    logic [63:0] prod_clip;
    logic [63:0] tm_full;
    logic signed [T_W-1:0] t_mag;
    lse_bus_t    bus_next;
    lse_bus_t    bus_reg;

    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    // The difference needs 33 bits, but its magnitude always fits in 32.
    assign diff     = {sample_x[DATA_W-1], sample_x} - {range_mid[DATA_W-1], range_mid};
    assign diff_mag = diff[DATA_W] ? (~diff + 1'b1) : diff;

    assign prod_next = 64'(d_mag_reg) * 64'(inv_half_span);

    assign clip      = prod_reg > X_ONE;
    assign prod_clip = clip ? X_ONE : prod_reg;

    generate
        if (SH > 0) begin : g_round
            assign tm_full = (prod_clip >> SH) + 64'(prod_clip[SH-1]);
        end else if (SH == 0) begin : g_exact
            assign tm_full = prod_clip;
        end else begin : g_widen
            assign tm_full = prod_clip << (-SH);
        end
    endgenerate

    assign t_mag = $signed(tm_full[T_W-1:0]);

    always_comb begin
        bus_next.t       = p_neg_reg ? -t_mag : t_mag;
        bus_next.p_prev  = '0;
        bus_next.p_cur   = P_ONE;
        bus_next.acc     = '0;
        bus_next.clamped = clip;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            d_neg_reg <= diff[DATA_W];
            d_mag_reg <= diff_mag[DATA_W-1:0];
        end
        if (en2 && v1_reg) begin
            prod_reg  <= prod_next;
            p_neg_reg <= d_neg_reg;
        end
        if (en3 && v2_reg) begin
            bus_reg <= bus_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_bus   = bus_reg;

endmodule

// ----- rtl/lse_cell.sv -----
// One recurrence cell: adds coef*P(TERM) to the sum and forms P(TERM+1).
// Three stages: products, rounding and numerator, reciprocal product. Uses lse_pkg.
module lse_cell #(
    parameter int TERM = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lse_pkg::lse_bus_t                 in_bus,
    input  logic signed [lse_pkg::COEF_W-1:0] coef,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lse_pkg::lse_bus_t                 out_bus
);
    import lse_pkg::*;

    localparam int TP_W   = T_W + P_W;
    localparam int CP_W   = COEF_W + P_W;
    localparam int NX_W   = NUM_W + RECIP_W;
    localparam int CP_SH  = IFRAC - GUARD;
    localparam logic signed [NUM_W-1:0] K_CUR  = NUM_W'(2 * TERM + 1);
    localparam logic signed [NUM_W-1:0] K_PREV = NUM_W'(TERM);
    localparam logic [RECIP_W-1:0]      RECIP  = RECIP_TAB[TERM+1];

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    // Stage 1: magnitudes and raw products.
    logic [T_W-1:0]    t_mag;
    logic [P_W-1:0]    p_mag;
    logic [COEF_W-1:0] c_mag;
    logic [TP_W-1:0]   tp_mag_next, tp_mag_reg;
    logic [CP_W-1:0]   cp_mag_next, cp_mag_reg;
    logic              tp_neg_reg, cp_neg_reg;
    lse_bus_t          b1_reg;

    // Stage 2: rounding, accumulation and the recurrence numerator.
    logic [TP_W-1:0]          tp_rnd;
    logic [CP_W-1:0]          cp_rnd;
    logic signed [NUM_W-1:0]  tp_abs, tp_val;
    logic signed [ACC_W-1:0]  cp_abs, cp_val;
    logic signed [NUM_W-1:0]  num;
    logic [NUM_W-1:0]         num_mag_next, num_mag_reg;
    logic                     num_neg_reg;
    lse_bus_t                 b2_next, b2_reg;

    // Stage 3: multiply by 1/(TERM+1).
    logic [NX_W-1:0]       nx_prod, nx_rnd;
    logic signed [P_W-1:0] p_abs;
    lse_bus_t              b3_next, b3_reg;

    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    assign t_mag = in_bus.t[T_W-1] ? (~in_bus.t + 1'b1) : in_bus.t;
    assign p_mag = in_bus.p_cur[P_W-1] ? (~in_bus.p_cur + 1'b1) : in_bus.p_cur;
    assign c_mag = coef[COEF_W-1] ? (~coef + 1'b1) : coef;
    assign tp_mag_next = TP_W'(t_mag) * TP_W'(p_mag);
    assign cp_mag_next = CP_W'(c_mag) * CP_W'(p_mag);

    // Rounding is on magnitudes, so ties go away from zero.
    assign tp_rnd = (tp_mag_reg >> IFRAC) + TP_W'(tp_mag_reg[IFRAC-1]);
    assign cp_rnd = (cp_mag_reg >> CP_SH) + CP_W'(cp_mag_reg[CP_SH-1]);
    assign tp_abs = $signed(tp_rnd[NUM_W-1:0]);
    assign cp_abs = $signed(cp_rnd[ACC_W-1:0]);
    assign tp_val = tp_neg_reg ? -tp_abs : tp_abs;
    assign cp_val = cp_neg_reg ? -cp_abs : cp_abs;
    assign num    = K_CUR * tp_val - K_PREV * NUM_W'(b1_reg.p_prev);
    assign num_mag_next = num[NUM_W-1] ? (~num + 1'b1) : num;

    always_comb begin
        b2_next     = b1_reg;
        b2_next.acc = b1_reg.acc + cp_val;
    end

    assign nx_prod = NX_W'(num_mag_reg) * NX_W'(RECIP);
    assign nx_rnd  = (nx_prod >> IFRAC) + NX_W'(nx_prod[IFRAC-1]);
    assign p_abs   = $signed(nx_rnd[P_W-1:0]);

    always_comb begin
        b3_next        = b2_reg;
        b3_next.p_prev = b2_reg.p_cur;
        b3_next.p_cur  = num_neg_reg ? -p_abs : p_abs;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            tp_mag_reg <= tp_mag_next;
            cp_mag_reg <= cp_mag_next;
            tp_neg_reg <= in_bus.t[T_W-1] ^ in_bus.p_cur[P_W-1];
            cp_neg_reg <= coef[COEF_W-1] ^ in_bus.p_cur[P_W-1];
            b1_reg     <= in_bus;
        end
        if (en2 && v1_reg) begin
            num_mag_reg <= num_mag_next;
            num_neg_reg <= num[NUM_W-1];
            b2_reg      <= b2_next;
        end
        if (en3 && v2_reg) begin
            b3_reg <= b3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_bus   = b3_reg;

endmodule

// ----- rtl/lse_back.sv -----
// Back end: rounds the accumulator to the output format, saturates it and
// holds the result item in the output register. Uses lse_pkg.
module lse_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  lse_pkg::lse_bus_t         in_bus,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [lse_pkg::DATA_W-1:0] m_tdata,
    output logic [1:0]                m_tuser
);
    import lse_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32'h7fff_ffff);
    localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

    logic v1_reg, v2_reg;
    logic en1, en2;

    logic [ACC_W-1:0]        a_mag;
    logic [ACC_W-1:0]        s_rnd;
    logic signed [SUM_W-1:0] s_abs;
    logic signed [SUM_W-1:0] sum_next, sum_reg;
    logic                    clamped_reg;

    logic [DATA_W-1:0] data_next, data_reg;
    logic              sat_next, sat_reg, clamped_out_reg;

    assign en2 = !v2_reg || m_tready;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    assign a_mag    = in_bus.acc[ACC_W-1] ? (~in_bus.acc + 1'b1) : in_bus.acc;
    assign s_rnd    = (a_mag >> GUARD) + ACC_W'(a_mag[GUARD-1]);
    assign s_abs    = $signed(s_rnd[SUM_W-1:0]);
    assign sum_next = in_bus.acc[ACC_W-1] ? -s_abs : s_abs;

    always_comb begin
        data_next = sum_reg[DATA_W-1:0];
        sat_next  = 1'b0;
        if (sum_reg > SAT_MAX) begin
            data_next = SAT_MAX[DATA_W-1:0];
            sat_next  = 1'b1;
        end else if (sum_reg < SAT_MIN) begin
            data_next = SAT_MIN[DATA_W-1:0];
            sat_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            sum_reg     <= sum_next;
            clamped_reg <= in_bus.clamped;
        end
        if (en2 && v1_reg) begin
            data_reg        <= data_next;
            sat_reg         <= sat_next;
            clamped_out_reg <= clamped_reg;
        end
    end

    assign m_tvalid = v2_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = {sat_reg, clamped_out_reg};

endmodule

// ----- rtl/legendre_series_evaluator_top.sv -----
// Legendre series evaluator: one result item per sample item, one item per clock
// unless m_tready holds the output. Each sample is scaled onto [-1,1] and clamped,
// then runs through a chain of NUM_TERMS recurrence cells and a rounding and
// saturating back end. On its way to m_tdata a sample passes the front end's stages,
// the three registered stages of every cell (two products, rounding and the
// numerator, the reciprocal product) and the back end's registers. Stalls on the
// result side fill empty stages first, so samples keep entering while a result waits.
// Configuration is written through cfg_* and is taken every cycle.
module legendre_series_evaluator_top #(
    parameter int NUM_TERMS = 6,
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lse_pkg::DATA_W-1:0]          s_tdata,   // [31:0] sample_x
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lse_pkg::DATA_W-1:0]          m_tdata,   // [31:0] series_value
    output logic [1:0]                          m_tuser,   // [0] clamped, [1] saturated
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lse_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lse_pkg::DATA_W-1:0]          cfg_data
);
    import lse_pkg::*;

    logic signed [DATA_W-1:0] range_mid_reg;
    logic [DATA_W-1:0]        inv_half_span_reg;
    logic signed [COEF_W-1:0] coef_reg [NUM_TERMS];

    lse_bus_t chain_bus   [NUM_TERMS+1];
    logic     chain_valid [NUM_TERMS+1];
    logic     chain_ready [NUM_TERMS+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_mid_reg     <= '0;
            inv_half_span_reg <= DATA_W'(32'h0001_0000);
        end else if (cfg_valid) begin
            if (cfg_index == REG_RANGE_MID) range_mid_reg <= cfg_data;
            if (cfg_index == REG_INV_HALF_SPAN) inv_half_span_reg <= cfg_data;
        end
    end

    generate
        for (genvar k = 0; k < NUM_TERMS; k++) begin : g_coef
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    coef_reg[k] <= '0;
                end else if (cfg_valid && cfg_index == REG_COEF_0 + CFG_IDX_W'(k)) begin
                    coef_reg[k] <= cfg_data;
                end
            end
        end
    endgenerate

    lse_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .sample_x     (s_tdata),
        .range_mid    (range_mid_reg),
        .inv_half_span(inv_half_span_reg),
        .out_valid    (chain_valid[0]),
        .out_ready    (chain_ready[0]),
        .out_bus      (chain_bus[0])
    );

    generate
        for (genvar n = 0; n < NUM_TERMS; n++) begin : g_cell
            lse_cell #(
                .TERM(n)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .in_valid (chain_valid[n]),
                .in_ready (chain_ready[n]),
                .in_bus   (chain_bus[n]),
                .coef     (coef_reg[n]),
                .out_valid(chain_valid[n+1]),
                .out_ready(chain_ready[n+1]),
                .out_bus  (chain_bus[n+1])
            );
        end
    endgenerate

    lse_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(chain_valid[NUM_TERMS]),
        .in_ready(chain_ready[NUM_TERMS]),
        .in_bus  (chain_bus[NUM_TERMS]),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

// ----- rtl/lse_checker.sv -----
// Port-level checks for the Legendre series evaluator, bound to its top level.
// Depends on lse_pkg and the assertion macro header.
`include "legendre_series_evaluator_top_macros.svh"

module lse_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [lse_pkg::DATA_W-1:0]  m_tdata,
    input logic [1:0]                  m_tuser
);
    import lse_pkg::*;

    // A result held back by the sink stays put.
    `LSE_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Reset empties the output register.
    `LSE_ASSERT_NXT_ALL(a_reset_empty, aclk, !aresetn, !m_tvalid)

    // With the output register empty the whole pipeline can move, so input is taken.
    `LSE_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)

    // A saturated result sits at one end of the 32-bit range.
    `LSE_ASSERT_IMP(a_sat_value, aclk, aresetn, m_tvalid && m_tuser[1], m_tdata == 32'h7fff_ffff || m_tdata == 32'h8000_0000)

endmodule

bind legendre_series_evaluator_top lse_checker u_lse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
